>>> rtl/core/annexb_nal_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ANNEXB_NAL_DEFRAMER_MACROS_SVH
`define ANNEXB_NAL_DEFRAMER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ANXB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ANXB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/anxb_pkg.sv
// Package for the Annex B NAL deframer: start code constants, result word type
// and the trailing-bit helper. It depends on nothing else.
package anxb_pkg;

  // Start code length in bytes (3 or 4); the window always has four entries.
  localparam int SC_LEN     = 4;
  localparam int WIN_DEPTH  = 4;
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam logic [2:0] SC_COUNT = 3'(SC_LEN);

  // Byte codes of the stream syntax.
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_SC_LAST  = 8'h01;
  localparam logic [7:0] BYTE_EPB      = 8'h03;
  localparam logic [7:0] BYTE_EPB_NEXT_MAX = 8'h03;
  localparam logic [1:0] ZERO_RUN_MAX  = 2'd2;

  // One result word.
  typedef struct packed {
    logic [7:0] rbsp_byte;
    logic       is_first;
    logic       is_last;
    logic       forbidden_bit;
    logic [1:0] ref_idc;
    logic [4:0] unit_type;
    logic [3:0] trailing_bits;
  } result_t;

  // Index of the lowest set bit plus one, or zero for a zero byte.
  function automatic logic [3:0] trailing_count(input logic [7:0] b);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) r = 4'(i + 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/annexb_nal_deframer.sv
// Top level of the Annex B NAL deframer: byte window, start code detection,
// emulation byte removal and a registered output with a skid stage.
// Depends on anxb_pkg and annexb_nal_deframer_macros.svh.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   input   | in        | in_valid / in_stall   | stream_byte
//   output  | out       | out_valid / out_stall | rbsp_byte, is_first, is_last,
//           |           |                       | forbidden_bit, ref_idc, unit_type,
//           |           |                       | trailing_bits
//
// One stream byte is accepted per cycle while in_stall is low; the byte it pushes out of
// the four-entry window, if any, is registered as a word in the output or skid stage.
// Payload bytes therefore leave four stream bytes behind their arrival.
// Reset empties the window and the output stages; no clearing pass is needed.
// A stalled output word holds; one more word waits in the skid stage, and
// in_stall rises only while that skid stage is occupied.
`include "annexb_nal_deframer_macros.svh"

module annexb_nal_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] stream_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] rbsp_byte,
  output logic       is_first,
  output logic       is_last,
  output logic       forbidden_bit,
  output logic [1:0] ref_idc,
  output logic [4:0] unit_type,
  output logic [3:0] trailing_bits
);

  // Stream state.
  logic [7:0] window [anxb_pkg::WIN_DEPTH];
  logic [7:0] window_next [anxb_pkg::WIN_DEPTH];
  logic [2:0] hold_count, hold_count_next;
  logic       inside_unit, inside_unit_next;
  logic       header_pending, header_pending_next;
  logic [1:0] zero_run, zero_run_next;

  // Output and skid stages.
  anxb_pkg::result_t out_word, skid_word, result_next;
  logic              skid_valid;

  logic       in_acc;
  logic       full;
  logic       sc_hit;
  logic       emit;
  logic       last;
  logic [7:0] evicted;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;

  // Window update, start code detection and emulation byte removal.
  always_comb begin
    window_next         = window;
    hold_count_next     = hold_count;
    inside_unit_next    = inside_unit;
    header_pending_next = header_pending;
    zero_run_next       = zero_run;
    emit                = 1'b0;
    last                = 1'b0;
    full                = (hold_count == anxb_pkg::SC_COUNT);
    evicted             = window[0];

    if (full) begin
      for (int i = 0; i < anxb_pkg::SC_LEN - 1; i++) begin
        window_next[i] = window[i + 1];
      end
      window_next[anxb_pkg::SC_LEN - 1] = stream_byte;
    end else begin
      window_next[hold_count[anxb_pkg::WIN_IDX_W-1:0]] = stream_byte;
      hold_count_next = hold_count + 3'd1;
    end

    sc_hit = (hold_count_next == anxb_pkg::SC_COUNT) &&
             (window_next[anxb_pkg::SC_LEN - 1] == anxb_pkg::BYTE_SC_LAST);
    for (int i = 0; i < anxb_pkg::SC_LEN - 1; i++) begin
      if (window_next[i] != anxb_pkg::BYTE_ZERO) sc_hit = 1'b0;
    end

    priority if (sc_hit) begin
      // The byte pushed out ahead of a start code closes the current unit.
      hold_count_next     = 3'd0;
      inside_unit_next    = 1'b1;
      header_pending_next = 1'b1;
      zero_run_next       = 2'd0;
      if (full && inside_unit) begin
        emit = 1'b1;
        last = 1'b1;
      end
    end else if (full && inside_unit) begin
      if (zero_run == anxb_pkg::ZERO_RUN_MAX && evicted == anxb_pkg::BYTE_EPB &&
          window_next[0] <= anxb_pkg::BYTE_EPB_NEXT_MAX) begin
        // Emulation prevention byte: drop it and restart the zero run.
        zero_run_next = 2'd0;
      end else begin
        emit                = 1'b1;
        header_pending_next = 1'b0;
        if (evicted == anxb_pkg::BYTE_ZERO) begin
          zero_run_next = (zero_run == anxb_pkg::ZERO_RUN_MAX) ?
                          anxb_pkg::ZERO_RUN_MAX : zero_run + 2'd1;
        end else begin
          zero_run_next = 2'd0;
        end
      end
    end else begin
      // Bytes ahead of the first start code fall away silently.
    end
  end

  // Result word for the evicted byte.
  always_comb begin
    result_next.rbsp_byte     = evicted;
    result_next.is_first      = header_pending;
    result_next.is_last       = last;
    result_next.forbidden_bit = header_pending ? evicted[7] : 1'b0;
    result_next.ref_idc       = header_pending ? evicted[6:5] : 2'd0;
    result_next.unit_type     = header_pending ? evicted[4:0] : 5'd0;
    result_next.trailing_bits = last ? anxb_pkg::trailing_count(evicted) : 4'd0;
  end

  // Stream state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count     <= 3'd0;
      inside_unit    <= 1'b0;
      header_pending <= 1'b0;
      zero_run       <= 2'd0;
    end else if (in_acc) begin
      hold_count     <= hold_count_next;
      inside_unit    <= inside_unit_next;
      header_pending <= header_pending_next;
      zero_run       <= zero_run_next;
    end
  end

  // Window bytes are only read once the count says they were written.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      window <= window_next;
    end
  end

  // Output register with a one-word skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc && emit;
      end
    end else if (in_acc && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_acc && emit) begin
        out_word <= result_next;
      end
    end else if (in_acc && emit) begin
      skid_word <= result_next;
    end
  end

  assign rbsp_byte     = out_word.rbsp_byte;
  assign is_first      = out_word.is_first;
  assign is_last       = out_word.is_last;
  assign forbidden_bit = out_word.forbidden_bit;
  assign ref_idc       = out_word.ref_idc;
  assign unit_type     = out_word.unit_type;
  assign trailing_bits = out_word.trailing_bits;

  // Checks on the window and output stages.
  `ANXB_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid, "skid word without output word")
  `ANXB_ASSERT_NEXT(a_sc_clear, in_acc && sc_hit, hold_count == 3'd0 && inside_unit, "no restart")
  `ANXB_ASSERT_SAME(a_no_emit_outside, !inside_unit, !emit, "emit before first start code")
  `ANXB_ASSERT_SAME(a_count_bound, 1'b1, hold_count <= anxb_pkg::SC_COUNT, "count overflow")

endmodule

>>> verif/tb.sv
// Self-checking testbench for annexb_nal_deframer: drives Annex B byte streams
// and compares every output word against an in-bench deframing predictor.
// Depends on anxb_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int STREAM_BYTES  = 1830;
  localparam int IDLE_PCT      = 14;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 16;

  // Scoreboard: deframes the accepted stream and checks the words that come out.
  class nal_scoreboard;
    logic [7:0] win [anxb_pkg::WIN_DEPTH];
    logic [2:0] win_count;
    bit         in_unit;
    bit         header_next;
    logic [1:0] zero_run;
    anxb_pkg::result_t expected_words [$];
    int         errors;
    int         bytes_in;
    int         words_checked;
    int         headers_seen;
    int         units_closed;
    int         epb_removed;

    function new();
      foreach (win[i]) win[i] = anxb_pkg::BYTE_ZERO;
      win_count   = 3'd0;
      in_unit     = 1'b0;
      header_next = 1'b0;
      zero_run    = 2'd0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Lowest set bit index plus one; zero for a zero byte.
    function logic [3:0] low_bit_rank(logic [7:0] b);
      logic [3:0] rank;
      rank = 4'd0;
      for (int i = 0; i < 8; i++) begin
        if (b[i] && rank == 4'd0) rank = 4'(i + 1);
      end
      return rank;
    endfunction

    // Push one accepted stream byte through the window and queue the word it causes.
    function void note_byte(logic [7:0] nb);
      logic [7:0] evicted;
      bit         have_evicted;
      bit         last;
      bit         emit;
      bit         sc_seen;
      anxb_pkg::result_t w;
      evicted      = anxb_pkg::BYTE_ZERO;
      have_evicted = 1'b0;
      last         = 1'b0;
      emit         = 1'b1;
      bytes_in++;
      if (win_count >= anxb_pkg::SC_COUNT) begin
        evicted      = win[0];
        have_evicted = 1'b1;
        for (int i = 0; i < anxb_pkg::SC_LEN - 1; i++) win[i] = win[i + 1];
        win[anxb_pkg::SC_LEN - 1] = nb;
      end else begin
        win[win_count[anxb_pkg::WIN_IDX_W-1:0]] = nb;
        win_count = win_count + 3'd1;
      end

      sc_seen = (win_count >= anxb_pkg::SC_COUNT) &&
                (win[anxb_pkg::SC_LEN - 1] == anxb_pkg::BYTE_SC_LAST);
      for (int i = 0; i < anxb_pkg::SC_LEN - 1; i++) begin
        if (win[i] != anxb_pkg::BYTE_ZERO) sc_seen = 1'b0;
      end

      if (sc_seen) begin
        // A start code empties the window; the byte it pushed out closes the unit.
        last      = 1'b1;
        win_count = 3'd0;
        if (!(have_evicted && in_unit)) begin
          header_next = 1'b1;
          zero_run    = 2'd0;
          emit        = 1'b0;
        end
        in_unit = 1'b1;
      end else if (!(have_evicted && in_unit)) begin
        emit = 1'b0;
      end else if (zero_run >= anxb_pkg::ZERO_RUN_MAX && evicted == anxb_pkg::BYTE_EPB &&
                   win[0] <= anxb_pkg::BYTE_EPB_NEXT_MAX) begin
        // Emulation prevention byte: dropped, and the zero run starts over.
        zero_run = 2'd0;
        emit     = 1'b0;
        epb_removed++;
      end

      if (emit) begin
        w = '0;
        w.rbsp_byte = evicted;
        w.is_first  = header_next;
        w.is_last   = last;
        if (header_next) begin
          w.forbidden_bit = evicted[7];
          w.ref_idc       = evicted[6:5];
          w.unit_type     = evicted[4:0];
          headers_seen++;
        end
        if (last) begin
          w.trailing_bits = low_bit_rank(evicted);
          units_closed++;
        end
        expected_words.push_back(w);
        if (last) begin
          header_next = 1'b1;
          zero_run    = 2'd0;
        end else begin
          header_next = 1'b0;
          if (evicted == anxb_pkg::BYTE_ZERO)
            zero_run = (zero_run >= anxb_pkg::ZERO_RUN_MAX) ?
                       anxb_pkg::ZERO_RUN_MAX : zero_run + 2'd1;
          else
            zero_run = 2'd0;
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] error: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("word %0d %s got 0x%02h want 0x%02h",
                                  words_checked, field, got, want));
    endtask

    // Compare one accepted output word with the oldest expected word.
    task check_word(anxb_pkg::result_t got);
      anxb_pkg::result_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, rbsp_byte 0x%02h", got.rbsp_byte));
      end else begin
        want = expected_words.pop_front();
        compare_field("rbsp_byte", got.rbsp_byte, want.rbsp_byte);
        compare_field("is_first", 8'(got.is_first), 8'(want.is_first));
        compare_field("is_last", 8'(got.is_last), 8'(want.is_last));
        compare_field("forbidden_bit", 8'(got.forbidden_bit), 8'(want.forbidden_bit));
        compare_field("ref_idc", 8'(got.ref_idc), 8'(want.ref_idc));
        compare_field("unit_type", 8'(got.unit_type), 8'(want.unit_type));
        compare_field("trailing_bits", 8'(got.trailing_bits), 8'(want.trailing_bits));
        words_checked++;
      end
    endtask
  endclass

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] stream_byte = 8'h00;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] rbsp_byte;
  logic       is_first;
  logic       is_last;
  logic       forbidden_bit;
  logic [1:0] ref_idc;
  logic [4:0] unit_type;
  logic [3:0] trailing_bits;

  nal_scoreboard sb = new();
  bit  quiet      = 1'b0;
  int  hold_reqs  = 0;
  int  hold_seen  = 0;
  int  hold_left  = 0;
  int  cycles     = 0;

  annexb_nal_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_byte   (stream_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rbsp_byte     (rbsp_byte),
    .is_first      (is_first),
    .is_last       (is_last),
    .forbidden_bit (forbidden_bit),
    .ref_idc       (ref_idc),
    .unit_type     (unit_type),
    .trailing_bits (trailing_bits)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d words outstanding.",
               CYCLE_LIMIT, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: check accepted words, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word({rbsp_byte, is_first, is_last, forbidden_bit, ref_idc, unit_type,
                     trailing_bits});
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      // Long hold-off so the window and skid stage fill and the input stalls.
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one stream byte, with random idle cycles first, and wait for acceptance.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
  endtask

  // Payload bytes lean toward zeros and emulation patterns.
  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return anxb_pkg::BYTE_ZERO;
    if (r < 50) return anxb_pkg::BYTE_EPB;
    if (r < 60) return 8'($urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  // One start code followed by a unit of random length and content.
  task automatic send_unit();
    int r;
    int body_len;
    r = $urandom_range(99);
    body_len = (r < 8) ? 0 : (r < 20) ? 1 : (r < 95) ? $urandom_range(2, 12)
                                                     : $urandom_range(13, 48);
    repeat (anxb_pkg::SC_LEN - 1) send_byte(anxb_pkg::BYTE_ZERO);
    send_byte(anxb_pkg::BYTE_SC_LAST);
    for (int i = 0; i < body_len; i++)
      send_byte((i == 0) ? 8'($urandom) : body_byte());
  endtask

  // Noise: raw random bytes or start codes that are short or over-long.
  task automatic send_noise();
    int r;
    r = $urandom_range(2);
    if (r == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      repeat ((r == 1) ? anxb_pkg::SC_LEN - 2 : anxb_pkg::SC_LEN)
        send_byte(anxb_pkg::BYTE_ZERO);
      send_byte(anxb_pkg::BYTE_SC_LAST);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Leading junk, header with the forbidden bit set, emulation byte removal with
  // the zero run restarting after it, an empty unit, and a 03 closing a unit.
  logic [7:0] opening_bytes [28] = '{
    8'hFF, 8'h80,
    8'h00, 8'h00, 8'h00, 8'h01,
    8'hE5, 8'h00, 8'h00, 8'h03, 8'h00, 8'h03, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h03,
    8'h00, 8'h00, 8'h00, 8'h01
  };

  initial begin
    bit paused;
    bit held;
    paused = 1'b0;
    held   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    while (sb.bytes_in < STREAM_BYTES) begin
      // Phases: a stretch with no idling and a long output hold inside it,
      // then one pause until the output has caught up.
      quiet <= (sb.bytes_in >= 500 && sb.bytes_in < 900);
      if (!held && sb.bytes_in >= 700) begin
        held = 1'b1;
        hold_reqs <= hold_reqs + 1;
      end
      if (!paused && sb.bytes_in >= 1000) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 12) send_noise();
      else send_unit();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d stream bytes; checked %0d words, %0d unit headers, %0d unit ends.",
             sb.bytes_in, sb.words_checked, sb.headers_seen, sb.units_closed);
    $display("Removed %0d emulation bytes; ran one long output hold and one full drain.",
             sb.epb_removed);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
